// ----- rtl/arpm_pkg.sv -----
`timescale 1ns / 1ps

package arpm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 16;
  localparam int SQ_W     = 31;
  localparam int DIV_W    = 10;
  localparam int HOLD_W   = 8;
  localparam int LEVEL_W  = 7;
  localparam int P_W      = DIV_W + LEVEL_W;
  localparam int Q_W      = 2 * P_W;
  localparam int IDX_W    = 2;
  localparam int BIT_W    = 3;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

  localparam logic [IDX_W-1:0] REG_RMS_DIVISOR = 2'd0;
  localparam logic [IDX_W-1:0] REG_HOLD_FRAMES = 2'd1;
  localparam logic [IDX_W-1:0] REG_DECAY_STEP  = 2'd2;

  localparam logic [DIV_W-1:0]   RST_RMS_DIVISOR = 10'd150;
  localparam logic [HOLD_W-1:0]  RST_HOLD_FRAMES = 8'd20;
  localparam logic [LEVEL_W-1:0] RST_DECAY_STEP  = 7'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_BIT,
    S_M1,
    S_M2,
    S_M3,
    S_PEAK
  } state_t;

endpackage

// ----- rtl/arpm_serial_mul.sv -----
`timescale 1ns / 1ps

module arpm_serial_mul #(
  parameter int AW = 47,
  parameter int BW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic          done,
  output logic [AW-1:0] prod
);

  logic [AW-1:0] areg;
  logic [BW-1:0] breg;
  logic          busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && breg[BW-1:1] == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // one multiplier bit per cycle, lsb first
  always_ff @(posedge clk) begin
    if (start) begin
      areg <= a;
      breg <= b;
      prod <= '0;
    end else if (busy) begin
      if (breg[0]) begin
        prod <= prod + areg;
      end
      areg <= areg << 1;
      breg <= breg >> 1;
    end
  end

endmodule

// ----- rtl/audio_rms_peak_meter_top.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// in        sink       in_valid / in_ready    sample, frame_end
// out       source     out_valid / out_ready  level, peak, overrun
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a sample's square is built one bit per cycle in the shared shift-add
// multiplier. a frame's last word adds the level search, seven candidate
// bits, each up to three multiplier passes. sync reset clears all control
// and returns the config defaults. a stalled result does not block sample
// intake, only the final update of the next frame.

module audio_rms_peak_meter_top #(
  parameter int MAX_FRAME_SAMPLES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [arpm_pkg::SAMPLE_W-1:0] sample,
  input  logic                          frame_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [arpm_pkg::LEVEL_W-1:0]  level,
  output logic [arpm_pkg::LEVEL_W-1:0]  peak,
  output logic                          overrun,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [arpm_pkg::IDX_W-1:0]    cfg_index,
  input  logic [arpm_pkg::DIV_W-1:0]    cfg_data
);

  import arpm_pkg::*;

  localparam int CW = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int SW = SQ_W + CW;
  localparam int AW = Q_W + CW;
  localparam int BW = (CW > P_W) ? CW : P_W;

  state_t state, state_next;

  logic [SW-1:0]      sum;
  logic [CW-1:0]      count;
  logic               dropped;
  logic               last;
  logic [LEVEL_W-1:0] peak_level;
  logic [HOLD_W-1:0]  hold;
  logic [LEVEL_W-1:0] best;
  logic [BIT_W-1:0]   idx;
  logic [DIV_W-1:0]   divisor;
  logic [HOLD_W-1:0]  hold_frames;
  logic [LEVEL_W-1:0] decay;

  logic               mul_start;
  logic [AW-1:0]      mul_a;
  logic [BW-1:0]      mul_b;
  logic               mul_done;
  logic [AW-1:0]      mul_prod;

  logic [MAG_W-1:0]   mag;
  logic               room;
  logic               accept;
  logic [LEVEL_W-1:0] cand;
  logic               cand_over;
  logic               fits;
  logic               slot_free;

  assign mag       = sample[SAMPLE_W-1] ? MAG_W'(-sample) : MAG_W'(sample);
  assign room      = count < CW'(MAX_FRAME_SAMPLES);
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign cand      = best | (LEVEL_W'(1) << idx);
  assign cand_over = cand > LEVEL_MAX;
  assign fits      = mul_prod <= AW'(sum);
  assign slot_free = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  arpm_serial_mul #(
    .AW(AW),
    .BW(BW)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (room) begin
            mul_start  = 1'b1;
            mul_a      = AW'(mag);
            mul_b      = BW'(mag);
            state_next = S_SQ;
          end else if (frame_end) begin
            state_next = S_BIT;
          end
        end
      end
      S_SQ: begin
        if (mul_done) begin
          state_next = last ? S_BIT : S_IDLE;
        end
      end
      S_BIT: begin
        if (cand_over) begin
          if (idx == '0) begin
            state_next = S_PEAK;
          end
        end else begin
          mul_start  = 1'b1;
          mul_a      = AW'(divisor);
          mul_b      = BW'(cand);
          state_next = S_M1;
        end
      end
      S_M1: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = AW'(mul_prod[P_W-1:0]);
          mul_b      = BW'(mul_prod[P_W-1:0]);
          state_next = S_M2;
        end
      end
      S_M2: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = AW'(mul_prod[Q_W-1:0]);
          mul_b      = BW'(count);
          state_next = S_M3;
        end
      end
      S_M3: begin
        if (mul_done) begin
          state_next = (idx == '0) ? S_PEAK : S_BIT;
        end
      end
      S_PEAK: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor     <= RST_RMS_DIVISOR;
      hold_frames <= RST_HOLD_FRAMES;
      decay       <= RST_DECAY_STEP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RMS_DIVISOR: divisor     <= cfg_data;
        REG_HOLD_FRAMES: hold_frames <= cfg_data[HOLD_W-1:0];
        REG_DECAY_STEP:  decay       <= cfg_data[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum        <= '0;
      count      <= '0;
      dropped    <= 1'b0;
      last       <= 1'b0;
      peak_level <= '0;
      hold       <= '0;
      best       <= '0;
      idx        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          best <= '0;
          idx  <= BIT_W'(LEVEL_W - 1);
          if (accept) begin
            last <= frame_end;
            if (!room) begin
              dropped <= 1'b1;
            end
          end
        end
        S_SQ: begin
          if (mul_done) begin
            sum   <= sum + SW'(mul_prod[SQ_W-1:0]);
            count <= count + CW'(1);
          end
        end
        S_BIT: begin
          if (cand_over && idx != '0) begin
            idx <= idx - BIT_W'(1);
          end
        end
        S_M3: begin
          if (mul_done) begin
            if (fits) begin
              best <= cand;
            end
            if (idx != '0) begin
              idx <= idx - BIT_W'(1);
            end
          end
        end
        S_PEAK: begin
          if (slot_free) begin
            if (best > peak_level) begin
              peak_level <= best;
              hold       <= hold_frames;
            end else if (hold != '0) begin
              hold <= hold - HOLD_W'(1);
            end else begin
              peak_level <= (peak_level >= decay) ? peak_level - decay : '0;
            end
            sum     <= '0;
            count   <= '0;
            dropped <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_PEAK && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PEAK && slot_free) begin
      level   <= best;
      overrun <= dropped;
      if (best > peak_level) begin
        peak <= best;
      end else if (hold != '0) begin
        peak <= peak_level;
      end else begin
        peak <= (peak_level >= decay) ? peak_level - decay : '0;
      end
    end
  end

endmodule

// ----- rtl/arpm_checker.sv -----
`timescale 1ns / 1ps

module arpm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [arpm_pkg::LEVEL_W-1:0] level,
  input logic [arpm_pkg::LEVEL_W-1:0] peak,
  input logic                         overrun,
  input logic                         cfg_valid,
  input logic                         cfg_ready
);

  import arpm_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(level) && $stable(peak)
      && $stable(overrun))
    else $error("result word changed while stalled");

  // level and peak stay clamped
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> level <= LEVEL_MAX && peak <= LEVEL_MAX)
    else $error("level or peak above clamp");

  // reset leaves no result pending
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word valid after reset");

  // config port never stalls
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind audio_rms_peak_meter_top arpm_checker u_arpm_checker (.*);
